FILE: design/mfdw_pkg.sv
// Shared types and constants for the motor feedback decoder with watchdog.
// No dependencies; imported by mfdw_entry, the top level and the bench.
package mfdw_pkg;

  // Item kinds carried on the mode input.
  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic CFG_ID_BASE = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Field widths fixed by the frame format and the result ports.
  localparam int unsigned ID_W      = 11;
  localparam int unsigned PAYLOAD_W = 56;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned CFG_W     = 16;

  // Register reset values.
  localparam logic [ID_W-1:0]  ID_BASE_RST = 11'd513;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd100;

  // One motor feedback record as held in the table.
  typedef struct packed {
    logic [WORD_W-1:0] angle;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] current;
    logic [BYTE_W-1:0] temp;
    logic              online;
  } motor_rec_t;

  // Per-entry update controls.
  typedef struct packed {
    logic load;
    logic tick;
  } entry_ctrl_t;

endpackage

FILE: design/motor_feedback_decoder_with_watchdog_top.sv
// Top level of the motor feedback decoder with per-motor online watchdog.
// Depends on mfdw_pkg and mfdw_entry.
//
// Every accepted item (a feedback frame, a one-millisecond tick or a record
// read) produces exactly one result beat, marked by done. The input register
// takes the item, and the table update feeds the result register, so done is
// high in the cycle after the input register takes the item. A new item may be
// started in every cycle while busy is low, so the sustained rate is one item
// per clock; busy is high only during reset and in the first cycle after it.
// Results are presented for a single cycle and cannot be held off, so the
// receiver must capture each beat when done is high. Configuration writes are
// taken whenever busy is low.
module motor_feedback_decoder_with_watchdog_top #(
  parameter int unsigned MOTOR_COUNT = 4,
  parameter int unsigned AGE_WIDTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode,
  input  logic [mfdw_pkg::ID_W-1:0]           frame_id,
  input  logic [mfdw_pkg::PAYLOAD_W-1:0]      payload,
  input  logic [mfdw_pkg::SEL_W-1:0]          motor_select,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [mfdw_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output logic                                frame_accepted,
  output logic [mfdw_pkg::SEL_W-1:0]          motor_index,
  output logic [mfdw_pkg::WORD_W-1:0]         angle_raw,
  output logic signed [mfdw_pkg::WORD_W-1:0]  rotor_speed,
  output logic signed [mfdw_pkg::WORD_W-1:0]  torque_current,
  output logic [mfdw_pkg::BYTE_W-1:0]         temperature,
  output logic                                record_online,
  output logic [mfdw_pkg::MASK_W-1:0]         online_mask,
  output logic                                all_online
);
  import mfdw_pkg::*;

  localparam int unsigned IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int unsigned MAX_MOTORS = 8;

  // Configuration registers.
  logic [ID_W-1:0]  id_base;
  logic [TMO_W-1:0] timeout_ticks;

  // Input register.
  logic                 in_valid;
  mode_t                in_mode;
  logic [ID_W-1:0]      in_frame_id;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [SEL_W-1:0]     in_sel;

  // Update and result logic.
  entry_ctrl_t          ctrl [MOTOR_COUNT];
  motor_rec_t           rec_next [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] online_vec;
  logic [ID_W:0]        id_diff;
  logic                 id_hit;
  logic [IDX_W-1:0]     frame_idx;
  logic [IDX_W+1:0]     frame_idx_wide;
  logic [IDX_W+1:0]     sel_wide;
  logic [IDX_W-1:0]     sel_idx;
  logic                 sel_ok;
  logic [MAX_MOTORS-1:0] mask_full;
  logic                 accepted_next;
  logic [SEL_W-1:0]     index_next;
  motor_rec_t           rec_out_next;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = ~busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base       <= ID_BASE_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ID_BASE: id_base       <= cfg_data[ID_W-1:0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data[TMO_W-1:0];
        default:     ;
      endcase
    end
  end

  // Capture the incoming beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_mode     <= mode_t'(mode);
    in_frame_id <= frame_id;
    in_payload  <= payload;
    in_sel      <= motor_select;
  end

  // Identifier range check; the difference is one bit wider so no wrap occurs.
  assign id_diff        = {1'b0, in_frame_id} - {1'b0, id_base};
  assign id_hit         = (in_frame_id >= id_base) && (id_diff < (ID_W+1)'(MOTOR_COUNT));
  assign frame_idx      = id_diff[IDX_W-1:0];
  assign frame_idx_wide = (IDX_W+2)'(frame_idx);

  // Read selection; entries beyond the table report zeros.
  assign sel_wide = (IDX_W+2)'(in_sel);
  assign sel_idx  = sel_wide[IDX_W-1:0];
  assign sel_ok   = 32'(in_sel) < MOTOR_COUNT;

  // Motor entries.
  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_entry
    always_comb begin
      ctrl[g].load = in_valid && (in_mode == MODE_FRAME) && id_hit &&
                     (frame_idx == IDX_W'(g));
      ctrl[g].tick = in_valid && (in_mode == MODE_TICK);
    end

    mfdw_entry #(
      .AGE_WIDTH (AGE_WIDTH)
    ) u_entry (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[g]),
      .payload  (in_payload),
      .timeout  (timeout_ticks),
      .rec_next (rec_next[g])
    );

    assign online_vec[g] = rec_next[g].online;
  end

  // Online mask over the updated flags.
  always_comb begin
    mask_full = '0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      mask_full[i] = online_vec[i];
    end
  end

  // Result selection from the updated table.
  always_comb begin
    accepted_next = 1'b0;
    index_next    = '0;
    rec_out_next  = '0;
    unique case (in_mode)
      MODE_FRAME: begin
        if (id_hit) begin
          accepted_next = 1'b1;
          index_next    = frame_idx_wide[SEL_W-1:0];
          rec_out_next  = rec_next[frame_idx];
        end
      end
      MODE_READ: begin
        index_next = in_sel;
        if (sel_ok) begin
          rec_out_next = rec_next[sel_idx];
        end
      end
      default: ;
    endcase
  end

  // Result register with its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    frame_accepted <= accepted_next;
    motor_index    <= index_next;
    angle_raw      <= rec_out_next.angle;
    rotor_speed    <= rec_out_next.speed;
    torque_current <= rec_out_next.current;
    temperature    <= rec_out_next.temp;
    record_online  <= rec_out_next.online;
    online_mask    <= mask_full[MASK_W-1:0];
    all_online     <= &online_vec;
  end

endmodule

FILE: design/mfdw_entry.sv
// One motor table entry: feedback record, online flag and watchdog age.
// Depends on mfdw_pkg.
module mfdw_entry #(
  parameter int unsigned AGE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mfdw_pkg::entry_ctrl_t              ctrl,
  input  logic [mfdw_pkg::PAYLOAD_W-1:0]     payload,
  input  logic [mfdw_pkg::TMO_W-1:0]         timeout,
  output mfdw_pkg::motor_rec_t               rec_next
);
  import mfdw_pkg::*;

  localparam int unsigned CMP_W = (AGE_WIDTH > TMO_W) ? AGE_WIDTH : TMO_W;

  motor_rec_t           rec;
  logic [AGE_WIDTH-1:0] age;
  logic [AGE_WIDTH-1:0] age_next;
  logic [AGE_WIDTH-1:0] age_inc;

  // Saturating age count; the comparison against the timeout uses the new age.
  assign age_inc = (age != {AGE_WIDTH{1'b1}}) ? age + 1'b1 : age;

  // Next record: a frame loads decoded fields, a tick ages the entry and clears online past the timeout.
  always_comb begin
    rec_next = rec;
    age_next = age;
    if (ctrl.load) begin
      rec_next.angle   = payload[5*BYTE_W +: WORD_W];
      rec_next.speed   = payload[3*BYTE_W +: WORD_W];
      rec_next.current = payload[BYTE_W +: WORD_W];
      rec_next.temp    = payload[BYTE_W-1:0];
      rec_next.online  = 1'b1;
      age_next         = '0;
    end else if (ctrl.tick) begin
      age_next = age_inc;
      if (CMP_W'(age_inc) > CMP_W'(timeout)) begin
        rec_next.online = 1'b0;
      end
    end
  end

  // Entry storage, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
      age <= '0;
    end else begin
      rec <= rec_next;
      age <= age_next;
    end
  end

endmodule

FILE: bench/tb_motor_feedback_decoder_with_watchdog_top.sv
`timescale 1ns / 1ps
// Self-checking bench for motor_feedback_decoder_with_watchdog_top: frames, ticks and reads
// are checked against an in-bench model of the record table and the online watchdog.
// Depends on mfdw_pkg and the design top level; needs no files or arguments.
module tb_motor_feedback_decoder_with_watchdog_top;
  import mfdw_pkg::*;

  localparam int unsigned MOTORS   = 4;
  localparam int unsigned AGE_TOP  = 65535;
  localparam int unsigned PHASES   = 6;
  localparam int unsigned PHASE_SZ = 225;

  // One input beat as the bench drives it.
  typedef struct {
    mode_t                mode;
    logic [ID_W-1:0]      fid;
    logic [PAYLOAD_W-1:0] data;
    logic [SEL_W-1:0]     sel;
  } fb_item_t;

  // One result beat as the block should present it.
  typedef struct {
    logic                     accepted;
    logic [SEL_W-1:0]         idx;
    logic [WORD_W-1:0]        angle;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] current;
    logic [BYTE_W-1:0]        temp;
    logic                     online;
    logic [MASK_W-1:0]        mask;
    logic                     all_on;
  } fb_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = MODE_FRAME;
  logic [ID_W-1:0] frame_id = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic [SEL_W-1:0] motor_select = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_ID_BASE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic frame_accepted;
  logic [SEL_W-1:0] motor_index;
  logic [WORD_W-1:0] angle_raw;
  logic signed [WORD_W-1:0] rotor_speed;
  logic signed [WORD_W-1:0] torque_current;
  logic [BYTE_W-1:0] temperature;
  logic record_online;
  logic [MASK_W-1:0] online_mask;
  logic all_online;

  motor_feedback_decoder_with_watchdog_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .frame_id(frame_id), .payload(payload), .motor_select(motor_select),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done), .frame_accepted(frame_accepted), .motor_index(motor_index),
    .angle_raw(angle_raw), .rotor_speed(rotor_speed), .torque_current(torque_current),
    .temperature(temperature), .record_online(record_online),
    .online_mask(online_mask), .all_online(all_online)
  );

  // Bench copy of the record table, watchdog ages and registers.
  logic [WORD_W-1:0] angle_mem [MOTORS];
  logic [WORD_W-1:0] speed_mem [MOTORS];
  logic [WORD_W-1:0] current_mem [MOTORS];
  logic [BYTE_W-1:0] temp_mem [MOTORS];
  logic [MOTORS-1:0] online_bits;
  int unsigned       age_cnt [MOTORS];
  logic [ID_W-1:0]   base_id;
  logic [TMO_W-1:0]  tmo_ticks;

  fb_item_t   items_to_send [$];
  fb_result_t motor_results_due [$];
  fb_item_t   in_flight;
  int unsigned sender_idle_pct = 0;

  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_stored = 0;
  int unsigned n_ignored = 0;
  int unsigned n_ticks = 0;
  int unsigned n_reads = 0;
  int unsigned n_dropouts = 0;
  int unsigned n_all_on = 0;

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one beat to the model and returns the result it should produce.
  function automatic fb_result_t decode_item(fb_item_t it);
    fb_result_t r;
    int unsigned k;
    r = '{default: '0};
    case (it.mode)
      MODE_FRAME: begin
        if (int'(it.fid) >= int'(base_id) && int'(it.fid) < int'(base_id) + MOTORS) begin
          k = it.fid - base_id;
          angle_mem[k] = it.data[55:40];
          speed_mem[k] = it.data[39:24];
          current_mem[k] = it.data[23:8];
          temp_mem[k] = it.data[7:0];
          online_bits[k] = 1'b1;
          age_cnt[k] = 0;
          r.accepted = 1'b1;
          r.idx = SEL_W'(k);
          n_stored++;
        end else begin
          n_ignored++;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < MOTORS; i++) begin
          if (age_cnt[i] < AGE_TOP) age_cnt[i]++;
          if (age_cnt[i] > tmo_ticks && online_bits[i]) begin
            online_bits[i] = 1'b0;
            n_dropouts++;
          end
        end
        n_ticks++;
      end
      MODE_READ: begin
        r.idx = it.sel;
        n_reads++;
      end
      default: ;
    endcase
    // Frames that hit an entry and reads report the addressed record.
    if (r.accepted || it.mode == MODE_READ) begin
      r.angle = angle_mem[r.idx];
      r.speed = speed_mem[r.idx];
      r.current = current_mem[r.idx];
      r.temp = temp_mem[r.idx];
      r.online = online_bits[r.idx];
    end
    r.mask = online_bits;
    r.all_on = &online_bits;
    if (r.all_on) n_all_on++;
    return r;
  endfunction

  function automatic fb_item_t mk_item(mode_t m, int fid, logic [PAYLOAD_W-1:0] d, int s);
    fb_item_t it;
    it.mode = m;
    it.fid = ID_W'(fid);
    it.data = d;
    it.sel = SEL_W'(s);
    return it;
  endfunction

  // Payloads mix field extremes with random bytes.
  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {16'hFFFF, 16'h8000, 16'h8000, 8'hFF};
      3: return {16'h0000, 16'h7FFF, 16'h7FFF, 8'h00};
      default: return raw[PAYLOAD_W-1:0];
    endcase
  endfunction

  // Random beat: frames mostly aimed at the motors kept alive, some near misses.
  function automatic fb_item_t pick_item(logic [MOTORS-1:0] alive);
    fb_item_t it;
    int k;
    int fid;
    int roll;
    it = mk_item(MODE_READ, $urandom_range(2047), pick_payload(), $urandom_range(3));
    roll = $urandom_range(99);
    if (roll < 45) begin
      it.mode = MODE_FRAME;
      roll = $urandom_range(99);
      if (roll < 75) begin
        do k = $urandom_range(MOTORS - 1); while (!alive[k]);
        fid = base_id + k;
      end else if (roll < 90) begin
        fid = $urandom_range(1) ? int'(base_id) - 1 : int'(base_id) + MOTORS;
      end else begin
        fid = $urandom_range(2047);
      end
      if (fid >= 0 && fid <= 2047) it.fid = ID_W'(fid);
    end else if (roll < 80) begin
      it.mode = MODE_TICK;
    end
    return it;
  endfunction

  // Item driver: takes beats off the queue, idling at the phase's rate.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        motor_results_due.push_back(decode_item(in_flight));
      end
      if (!start || !busy) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_flight = items_to_send.pop_front();
          start <= 1'b1;
          mode <= in_flight.mode;
          frame_id <= in_flight.fid;
          payload <= in_flight.data;
          motor_select <= in_flight.sel;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result monitor: every done beat must match the oldest expectation.
  always @(posedge clk) begin
    fb_result_t want;
    if (!rst && done) begin
      if (motor_results_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat, expected none, actual mask %0h", $time,
                 online_mask);
      end else begin
        want = motor_results_due.pop_front();
        n_checked++;
        check_field("frame_accepted", want.accepted, frame_accepted);
        check_field("motor_index", want.idx, motor_index);
        check_field("angle_raw", want.angle, angle_raw);
        check_field("rotor_speed", want.speed, rotor_speed);
        check_field("torque_current", want.current, torque_current);
        check_field("temperature", want.temp, temperature);
        check_field("record_online", want.online, record_online);
        check_field("online_mask", want.mask, online_mask);
        check_field("all_online", want.all_on, all_online);
      end
    end
  end

  // One register write beat; the model follows at the handshake.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ID_BASE) base_id = val[ID_W-1:0];
    else tmo_ticks = val;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued beat is taken and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (items_to_send.size() != 0 || start || motor_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Main sequence: reset, directed beats, then random phases under several settings.
  initial begin
    int unsigned idle_plan [4] = '{0, 73, 0, 17};
    int unsigned id_plan [PHASES];
    int unsigned tmo_plan [PHASES];
    logic [MOTORS-1:0] alive;

    base_id = ID_BASE_RST;
    tmo_ticks = TIMEOUT_RST;
    online_bits = '0;
    for (int i = 0; i < MOTORS; i++) begin
      angle_mem[i] = '0;
      speed_mem[i] = '0;
      current_mem[i] = '0;
      temp_mem[i] = '0;
      age_cnt[i] = 0;
    end
    id_plan = '{513, 0, 2047, 2044, $urandom_range(2047), 1024};
    tmo_plan = '{100, 1, 65534, 3, $urandom_range(1, 300), 10};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, every entry loaded, near misses and edges of the id range.
    items_to_send.push_back(mk_item(MODE_READ, 0, '0, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 513, '0, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 514, '1, 3));
    items_to_send.push_back(mk_item(MODE_FRAME, 515, {16'hFFFF, 16'h8000, 16'h8000, 8'hFF}, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 516, {16'h0000, 16'h7FFF, 16'h7FFF, 8'h80}, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 512, '1, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 517, '1, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 0, '1, 0));
    items_to_send.push_back(mk_item(MODE_FRAME, 2047, '1, 0));
    items_to_send.push_back(mk_item(MODE_TICK, 2047, '1, 3));
    items_to_send.push_back(mk_item(MODE_TICK, 0, '0, 0));
    for (int i = 0; i < MOTORS; i++) begin
      items_to_send.push_back(mk_item(MODE_READ, 513, '0, i));
    end
    wait_drained();

    // Random phases, each under its own register setting and an idle rate from idle_plan.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_ID_BASE, CFG_W'(id_plan[p]));
      write_reg(CFG_TIMEOUT, CFG_W'(tmo_plan[p]));
      sender_idle_pct = idle_plan[p % 4];
      alive = 4'hF;
      for (int n = 0; n < PHASE_SZ; n++) begin
        // Every 60 beats the live set is redrawn, all motors or a subset, so the watchdog can fire.
        if (n % 60 == 0) begin
          alive = $urandom_range(1) ? 4'hF : 4'($urandom_range(1, 15));
        end
        items_to_send.push_back(pick_item(alive));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results over %0d settings: %0d frames stored, %0d ignored,",
             n_checked, PHASES + 1, n_stored, n_ignored);
    $display("%0d ticks, %0d reads, %0d watchdog dropouts, all motors online in %0d results.",
             n_ticks, n_reads, n_dropouts, n_all_on);
    if (n_errors == 0) begin
      $display("tb_motor_feedback_decoder_with_watchdog_top: done, clean");
    end else begin
      $display("tb_motor_feedback_decoder_with_watchdog_top: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2000000;
    $display("tb_motor_feedback_decoder_with_watchdog_top: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
design/mfdw_pkg.sv
design/mfdw_entry.sv
design/motor_feedback_decoder_with_watchdog_top.sv
bench/tb_motor_feedback_decoder_with_watchdog_top.sv
